FILE: hw/rtl/day_number_to_date_assert.svh
// Assertion macros used by the RTL of the day number to date converter.
`ifndef DAY_NUMBER_TO_DATE_ASSERT_SVH
`define DAY_NUMBER_TO_DATE_ASSERT_SVH

// Checked only while the block is out of reset.
`define DNTD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DNTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dntd_pkg.sv
package dntd_pkg;

    localparam int unsigned DAY_W   = 17;
    localparam int unsigned ALU_W   = DAY_W + 1;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned YEAR_W  = 8;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned WDAY_W  = 3;

    localparam logic [DAY_W-1:0]   MAX_DAY_NUMBER = 17'd93503;
    localparam logic [YEAR_W-1:0]  LAST_YEAR      = 8'd255;
    localparam logic [MONTH_W-1:0] LAST_MONTH     = 4'd11;
    localparam logic [MONTH_W-1:0] FEBRUARY       = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_1900      = 8'd0;
    localparam logic [YEAR_W-1:0]  YEAR_2100      = 8'd200;
    localparam logic [DAY_W-1:0]   WEEKDAY_BIAS   = 17'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } t_state;

    typedef enum logic {
        ALU_STEP,
        ALU_REM
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [DAY_W-1:0]  acc;
        logic [DAY_W-1:0]  limit;
        logic [LEN_W-1:0]  len;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             over;
    } t_alu_rsp;

    // Years are offsets from 1900. Within 1900..2155 only 1900 and 2100 are
    // century years that fail the rule; 2000 keeps its leap day.
    function automatic logic is_leap(input logic [YEAR_W-1:0] yoff);
        return (yoff[1:0] == 2'b00) && (yoff != YEAR_1900) && (yoff != YEAR_2100);
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic [YEAR_W-1:0] yoff);
        return is_leap(yoff) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DOM_W-1:0] d;
        case (m) inside
            FEBRUARY:                d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return {{(LEN_W-DOM_W){1'b0}}, d};
    endfunction

    // Since 8 leaves 1 modulo 7, summing octal digits keeps the residue.
    function automatic logic [WDAY_W-1:0] mod7(input logic [ALU_W-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = '0;
        for (int i = 0; i < ALU_W / 3; i++) begin
            s1 = s1 + {3'b000, v[3*i +: 3]};
        end
        s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
        s3 = {3'b000, s2[3]} + {1'b0, s2[2:0]};
        if (s3 >= 4'd7) begin
            s3 = s3 - 4'd7;
        end
        return s3[WDAY_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dntd_if.sv
interface dntd_in_if;
    import dntd_pkg::*;
    logic             valid;
    logic             ready;
    logic [DAY_W-1:0] day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

interface dntd_out_if;
    import dntd_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_offset;
    logic [MONTH_W-1:0] month_number;
    logic [DOM_W-1:0]   day_of_month;
    logic [WDAY_W-1:0]  weekday;
    logic               range_error;

    modport source (output valid, output year_offset, output month_number,
                    output day_of_month, output weekday, output range_error,
                    input ready);
    modport sink   (input valid, input year_offset, input month_number,
                    input day_of_month, input weekday, input range_error,
                    output ready);
endinterface

FILE: hw/rtl/dntd_alu.sv
module dntd_alu
    import dntd_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] w_a;
    logic [ALU_W-1:0] w_b;
    logic [1:0]       w_cin;

    // Step mode adds a year or month length to the running total and checks
    // it against the target. Remainder mode forms limit - acc + 1.
    always_comb begin
        unique case (i_req.op)
            ALU_REM: begin
                w_a   = {1'b0, i_req.limit};
                w_b   = {1'b0, ~i_req.acc};
                w_cin = 2'd2;
            end
            default: begin
                w_a   = {1'b0, i_req.acc};
                w_b   = {{(ALU_W-LEN_W){1'b0}}, i_req.len};
                w_cin = 2'd0;
            end
        endcase
    end

    assign o_rsp.res  = w_a + w_b + {{(ALU_W-2){1'b0}}, w_cin};
    assign o_rsp.over = o_rsp.res > {1'b0, i_req.limit};

endmodule

FILE: hw/rtl/day_number_to_date.sv
// Converts a day number counted from 1900 into year offset, month, day of
// month and weekday, one word at a time. After a word is taken the block
// walks whole years from 1900 and then whole months of the found year, one
// step per cycle through a single shared adder and comparator. A word above
// 93503 skips the walk and finishes with range_error set. The finished
// result sits in an output register, so the next word is taken while the
// previous one waits there.
module day_number_to_date
    import dntd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dntd_in_if.sink           i_in,
    dntd_out_if.source        o_out
);

    t_state             r_state;
    t_state             n_state;
    logic [DAY_W-1:0]   r_n;
    logic [DAY_W-1:0]   r_acc;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [WDAY_W-1:0]  r_wday;
    logic               r_err;

    logic               r_out_valid;
    logic [YEAR_W-1:0]  r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DOM_W-1:0]   r_o_day;
    logic [WDAY_W-1:0]  r_o_wday;
    logic               r_o_err;

    t_alu_req           w_req;
    t_alu_rsp           w_rsp;
    logic               w_accept;
    logic               w_bad;
    logic               w_out_load;
    logic               w_step;

    dntd_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_accept = i_in.valid && i_in.ready;
    assign w_bad    = i_in.day_number > MAX_DAY_NUMBER;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = w_bad ? ST_FINISH : ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (w_rsp.over || (r_year == LAST_YEAR)) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (w_rsp.over || (r_month == LAST_MONTH)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        w_out_load  = 1'b0;
        w_step      = 1'b0;
        w_req.op    = ALU_STEP;
        w_req.acc   = r_acc;
        w_req.limit = r_n;
        w_req.len   = year_len(r_year);
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_YEAR: begin
                w_step = !w_rsp.over && (r_year != LAST_YEAR);
            end
            ST_MONTH: begin
                w_req.len = month_len(r_month, is_leap(r_year));
                w_step    = !w_rsp.over && (r_month != LAST_MONTH);
            end
            ST_FINISH: begin
                w_req.op   = ALU_REM;
                w_out_load = !r_out_valid || o_out.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // Day numbers 0, 1 and 2 all land on the first of January 1900.
            r_n     <= (i_in.day_number < 17'd2) ? '0 : i_in.day_number - 17'd2;
            r_acc   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_err   <= w_bad;
            r_wday  <= mod7({1'b0, i_in.day_number} + {1'b0, WEEKDAY_BIAS});
        end else if (w_step) begin
            r_acc <= w_rsp.res[DAY_W-1:0];
            if (r_state == ST_YEAR) begin
                r_year <= r_year + 8'd1;
            end else begin
                r_month <= r_month + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_err <= r_err;
            if (r_err) begin
                r_o_year  <= '0;
                r_o_month <= '0;
                r_o_day   <= '0;
                r_o_wday  <= '0;
            end else begin
                r_o_year  <= r_year;
                r_o_month <= r_month + 4'd1;
                r_o_day   <= w_rsp.res[DOM_W-1:0];
                r_o_wday  <= r_wday;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.year_offset  = r_o_year;
    assign o_out.month_number = r_o_month;
    assign o_out.day_of_month = r_o_day;
    assign o_out.weekday      = r_o_wday;
    assign o_out.range_error  = r_o_err;

`include "day_number_to_date_assert.svh"

    `DNTD_ASSERT(a_acc_bound, i_clk, i_rst_n,
        ((r_state == ST_YEAR) || (r_state == ST_MONTH)) |-> (r_acc <= r_n),
        "running total passed the target day")
    `DNTD_ASSERT(a_err_zero, i_clk, i_rst_n,
        (o_out.valid && o_out.range_error) |->
            ((o_out.month_number == 4'd0) && (o_out.day_of_month == 5'd0)),
        "rejected word carries a date")
    `DNTD_ASSERT(a_date_ok, i_clk, i_rst_n,
        (o_out.valid && !o_out.range_error) |->
            ((o_out.month_number != 4'd0) && (o_out.month_number <= 4'd12)
             && (o_out.day_of_month != 5'd0) && (o_out.weekday <= 3'd6)),
        "result date out of range")
    `DNTD_ASSERT(a_accept_busy, i_clk, i_rst_n,
        w_accept |=> (r_state != ST_IDLE),
        "sequencer stayed idle after taking a word")
    `DNTD_ASSERT_ALWAYS(a_reset_clear, i_clk,
        !i_rst_n |=> !o_out.valid,
        "output valid after reset")

endmodule
